### rtl/core/hbec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hbec_pkg;

    localparam int COORD_W  = 25;
    localparam int CUT_W    = 18;
    localparam int MAG_W    = COORD_W;          // |a - b| for two coordinates
    localparam int SQ_W     = 2 * MAG_W;
    localparam int D2_W     = SQ_W + 2;         // sum of three squares
    localparam int ROOT_W   = D2_W / 2;
    localparam int RECIP_INT_W = 10;            // 1000 fits in ten bits
    localparam int SCALE_W  = 15;
    localparam int ENERGY_W = 25;               // signed, plus or minus 10^7
    localparam int ELIM_W   = ENERGY_W - 1;

    localparam int RECIP_FRAC_BITS_DEF = 20;

    localparam logic [D2_W-1:0]     GATE_D2   = D2_W'(49000000);
    localparam logic [SCALE_W-1:0]  E_SCALE   = SCALE_W'(27888);
    localparam logic [ELIM_W-1:0]   E_LIMIT   = ELIM_W'(10000000);
    localparam logic [CUT_W-1:0]    CUTOFF_RST = CUT_W'(-500);

endpackage
`default_nettype wire

### rtl/core/hbec_dist2.sv
`timescale 1ns / 1ps
`default_nettype none
module hbec_dist2 (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_en,
    input  wire logic signed [hbec_pkg::COORD_W-1:0]    i_ax,
    input  wire logic signed [hbec_pkg::COORD_W-1:0]    i_ay,
    input  wire logic signed [hbec_pkg::COORD_W-1:0]    i_az,
    input  wire logic signed [hbec_pkg::COORD_W-1:0]    i_bx,
    input  wire logic signed [hbec_pkg::COORD_W-1:0]    i_by,
    input  wire logic signed [hbec_pkg::COORD_W-1:0]    i_bz,
    output logic             [hbec_pkg::D2_W-1:0]       o_d2
);

    localparam int DW = hbec_pkg::COORD_W + 1;

    logic signed [DW-1:0]             n_diff [3];
    logic        [hbec_pkg::MAG_W-1:0] r_mag  [3];
    logic        [hbec_pkg::SQ_W-1:0]  r_sq   [3];
    logic        [hbec_pkg::D2_W-1:0]  r_d2;

    always_comb begin
        n_diff[0] = DW'(i_ax) - DW'(i_bx);
        n_diff[1] = DW'(i_ay) - DW'(i_by);
        n_diff[2] = DW'(i_az) - DW'(i_bz);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_mag[k] <= n_diff[k][DW-1] ? hbec_pkg::MAG_W'(-n_diff[k])
                                            : hbec_pkg::MAG_W'(n_diff[k]);
                r_sq[k]  <= r_mag[k] * r_mag[k];
            end
            r_d2 <= hbec_pkg::D2_W'(r_sq[0]) + hbec_pkg::D2_W'(r_sq[1])
                  + hbec_pkg::D2_W'(r_sq[2]);
        end
    end

    assign o_d2 = r_d2;

endmodule
`default_nettype wire

### rtl/core/hbec_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module hbec_isqrt (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic [hbec_pkg::D2_W-1:0]       i_d2,
    output logic      [hbec_pkg::ROOT_W-1:0]     o_root
);

    localparam int NR = hbec_pkg::ROOT_W;
    localparam int DW = hbec_pkg::D2_W;
    localparam int RW = NR + 2;

    logic [NR-1:0] r_root [NR];
    logic [RW-1:0] r_rem  [NR-1];
    logic [DW-1:0] r_rad  [NR-1];

    // one root bit per stage, two radicand bits consumed each time
    for (genvar k = 0; k < NR; k++) begin : g_stage
        logic [RW-1:0] rem_in;
        logic [NR-1:0] root_in;
        logic [DW-1:0] rad_in;
        logic [RW-1:0] t;
        logic [RW-1:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_d2;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
        end

        assign t     = {rem_in[RW-3:0], rad_in[DW-1 -: 2]};
        assign trial = {root_in, 2'b01};
        assign ge    = t >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= {root_in[NR-2:0], ge};
            end
        end

        if (k < NR - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? t - trial : t;
                    r_rad[k] <= {rad_in[DW-3:0], 2'b00};
                end
            end
        end
    end

    assign o_root = r_root[NR-1];

endmodule
`default_nettype wire

### rtl/core/hbec_recip.sv
`timescale 1ns / 1ps
`default_nettype none
module hbec_recip #(
    parameter int RECIP_FRAC_BITS = hbec_pkg::RECIP_FRAC_BITS_DEF
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_en,
    input  wire logic [hbec_pkg::ROOT_W-1:0]                  i_root,
    output logic [RECIP_FRAC_BITS+hbec_pkg::RECIP_INT_W-1:0]  o_recip
);

    localparam int QW = RECIP_FRAC_BITS + hbec_pkg::RECIP_INT_W;
    localparam int DW = hbec_pkg::ROOT_W;
    localparam int RW = DW + 1;
    localparam logic [QW-1:0] NUM = {hbec_pkg::RECIP_INT_W'(1000),
                                     {RECIP_FRAC_BITS{1'b0}}};

    logic [QW-1:0] r_q   [QW];
    logic [RW-1:0] r_rem [QW-1];
    logic [DW-1:0] r_d   [QW-1];
    logic [DW-1:0] n_d0;

    // coincident atoms count as one milli-angstrom apart
    assign n_d0 = (i_root == '0) ? DW'(1) : i_root;

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [RW-1:0] rem_in;
        logic [QW-1:0] q_in;
        logic [DW-1:0] d_in;
        logic [RW-1:0] sh;
        logic          ge;

        if (j == 0) begin : g_first
            assign rem_in = '0;
            assign q_in   = '0;
            assign d_in   = n_d0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign q_in   = r_q[j-1];
            assign d_in   = r_d[j-1];
        end

        assign sh = {rem_in[DW-1:0], NUM[QW-1-j]};
        assign ge = sh >= {1'b0, d_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[j]   <= {q_in[QW-2:0], ge};
            end
        end

        if (j < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= ge ? sh - {1'b0, d_in} : sh;
                    r_d[j]   <= d_in;
                end
            end
        end
    end

    assign o_recip = r_q[QW-1];

endmodule
`default_nettype wire

### rtl/core/hbond_energy_check_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Hydrogen-bond test on one carbonyl/amide pair per beat, Kabsch-Sander
// electrostatic energy. A beat can enter every cycle; its result passes
// through the squared-distance registers, 26 square-root stages,
// RECIP_FRAC_BITS + 10 reciprocal divider stages, four energy stages and
// the output register. The pipeline moves as a whole: it
// stalls only while a result waits at the output. The cutoff is read at the
// last stage, so change it only when no beat is in flight.
module hbond_energy_check_unit #(
    parameter int RECIP_FRAC_BITS = hbec_pkg::RECIP_FRAC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic signed [hbec_pkg::COORD_W-1:0]   i_carb_c_x,
    input  wire logic signed [hbec_pkg::COORD_W-1:0]   i_carb_c_y,
    input  wire logic signed [hbec_pkg::COORD_W-1:0]   i_carb_c_z,
    input  wire logic signed [hbec_pkg::COORD_W-1:0]   i_carb_o_x,
    input  wire logic signed [hbec_pkg::COORD_W-1:0]   i_carb_o_y,
    input  wire logic signed [hbec_pkg::COORD_W-1:0]   i_carb_o_z,
    input  wire logic signed [hbec_pkg::COORD_W-1:0]   i_amide_n_x,
    input  wire logic signed [hbec_pkg::COORD_W-1:0]   i_amide_n_y,
    input  wire logic signed [hbec_pkg::COORD_W-1:0]   i_amide_n_z,
    input  wire logic signed [hbec_pkg::COORD_W-1:0]   i_amide_h_x,
    input  wire logic signed [hbec_pkg::COORD_W-1:0]   i_amide_h_y,
    input  wire logic signed [hbec_pkg::COORD_W-1:0]   i_amide_h_z,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic                                       o_bonded,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic signed [hbec_pkg::CUT_W-1:0]     i_cfg_energy_cutoff
);

    localparam int QW   = RECIP_FRAC_BITS + hbec_pkg::RECIP_INT_W;
    localparam int SW   = QW + 2;
    localparam int MW   = QW + 1;
    localparam int PW   = MW + hbec_pkg::SCALE_W;
    localparam int EW   = PW + 1 - RECIP_FRAC_BITS;
    localparam int NV   = 33 + QW;                 // valid stages before output
    localparam int GOFF = 3;                       // first stage holding the gate
    localparam int NG   = NV - GOFF;
    localparam int NR   = hbec_pkg::ROOT_W;
    localparam logic [PW:0] HALF = (PW + 1)'(1) << (RECIP_FRAC_BITS - 1);

    logic                               en;
    logic [NV-1:0]                      r_vld;
    logic [NG-1:0]                      r_gate;
    logic signed [hbec_pkg::CUT_W-1:0]  r_cutoff;

    logic [hbec_pkg::D2_W-1:0]   d2_on, d2_ch, d2_oh, d2_cn;
    logic [hbec_pkg::ROOT_W-1:0] rt_on, rt_ch, rt_oh, rt_cn;
    logic [QW-1:0]               rc_on, rc_ch, rc_oh, rc_cn;

    logic signed [SW-1:0]   r_sum;
    logic                   r_neg_b, r_neg_c, r_neg_d;
    logic [MW-1:0]          r_mag;
    logic [PW-1:0]          r_prod;
    logic [EW-1:0]          r_e;
    logic [PW:0]            n_rnd;
    logic [hbec_pkg::ELIM_W-1:0]          n_esat;
    logic signed [hbec_pkg::ENERGY_W-1:0] n_energy;
    logic signed [hbec_pkg::ENERGY_W-1:0] n_cut;

    assign en          = !o_valid || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= hbec_pkg::CUTOFF_RST;
        end else if (i_cfg_valid) begin
            r_cutoff <= i_cfg_energy_cutoff;
        end
    end

    hbec_dist2 u_d_on (.i_clk, .i_en(en), .i_ax(i_carb_o_x), .i_ay(i_carb_o_y),
        .i_az(i_carb_o_z), .i_bx(i_amide_n_x), .i_by(i_amide_n_y),
        .i_bz(i_amide_n_z), .o_d2(d2_on));
    hbec_dist2 u_d_ch (.i_clk, .i_en(en), .i_ax(i_carb_c_x), .i_ay(i_carb_c_y),
        .i_az(i_carb_c_z), .i_bx(i_amide_h_x), .i_by(i_amide_h_y),
        .i_bz(i_amide_h_z), .o_d2(d2_ch));
    hbec_dist2 u_d_oh (.i_clk, .i_en(en), .i_ax(i_carb_o_x), .i_ay(i_carb_o_y),
        .i_az(i_carb_o_z), .i_bx(i_amide_h_x), .i_by(i_amide_h_y),
        .i_bz(i_amide_h_z), .o_d2(d2_oh));
    hbec_dist2 u_d_cn (.i_clk, .i_en(en), .i_ax(i_carb_c_x), .i_ay(i_carb_c_y),
        .i_az(i_carb_c_z), .i_bx(i_amide_n_x), .i_by(i_amide_n_y),
        .i_bz(i_amide_n_z), .o_d2(d2_cn));

    hbec_isqrt u_s_on (.i_clk, .i_en(en), .i_d2(d2_on), .o_root(rt_on));
    hbec_isqrt u_s_ch (.i_clk, .i_en(en), .i_d2(d2_ch), .o_root(rt_ch));
    hbec_isqrt u_s_oh (.i_clk, .i_en(en), .i_d2(d2_oh), .o_root(rt_oh));
    hbec_isqrt u_s_cn (.i_clk, .i_en(en), .i_d2(d2_cn), .o_root(rt_cn));

    hbec_recip #(.RECIP_FRAC_BITS(RECIP_FRAC_BITS)) u_r_on (.i_clk, .i_en(en),
        .i_root(rt_on), .o_recip(rc_on));
    hbec_recip #(.RECIP_FRAC_BITS(RECIP_FRAC_BITS)) u_r_ch (.i_clk, .i_en(en),
        .i_root(rt_ch), .o_recip(rc_ch));
    hbec_recip #(.RECIP_FRAC_BITS(RECIP_FRAC_BITS)) u_r_oh (.i_clk, .i_en(en),
        .i_root(rt_oh), .o_recip(rc_oh));
    hbec_recip #(.RECIP_FRAC_BITS(RECIP_FRAC_BITS)) u_r_cn (.i_clk, .i_en(en),
        .i_root(rt_cn), .o_recip(rc_cn));

    // valid and c-n gate travel beside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_vld   <= {r_vld[NV-2:0], i_valid};
            o_valid <= r_vld[NV-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_gate <= {r_gate[NG-2:0], d2_cn <= hbec_pkg::GATE_D2};
        end
    end

    always_comb begin
        n_rnd    = {1'b0, r_prod} + HALF;
        n_esat   = (r_e > EW'(hbec_pkg::E_LIMIT)) ? hbec_pkg::E_LIMIT
                                                  : hbec_pkg::ELIM_W'(r_e);
        n_energy = r_neg_d ? -hbec_pkg::ENERGY_W'(n_esat)
                           : hbec_pkg::ENERGY_W'(n_esat);
        n_cut    = hbec_pkg::ENERGY_W'(r_cutoff);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum    <= SW'(rc_on) + SW'(rc_ch) - SW'(rc_oh) - SW'(rc_cn);
            r_neg_b  <= r_sum[SW-1];
            r_mag    <= r_sum[SW-1] ? MW'(-r_sum) : MW'(r_sum);
            r_neg_c  <= r_neg_b;
            r_prod   <= PW'(r_mag) * PW'(hbec_pkg::E_SCALE);
            r_neg_d  <= r_neg_c;
            r_e      <= n_rnd[PW:RECIP_FRAC_BITS];
            o_bonded <= r_gate[NG-1] && (n_energy < n_cut);
        end
    end

    // a reciprocal of a 26-bit distance is never zero
    a_recip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[GOFF + NR + QW - 1] |-> (rc_on != '0) && (rc_cn != '0))
        else $error("reciprocal came out zero");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld) && $stable(r_gate))
        else $error("pipeline moved while stalled");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with empty output");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && (r_vld == '0))
        else $error("valid survived reset");

endmodule
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
module tb;

    localparam int FRAC = hbec_pkg::RECIP_FRAC_BITS_DEF;
    localparam int LATENCY = FRAC + 44;
    localparam int STALL_LIMIT = 20000;

    typedef logic signed [hbec_pkg::COORD_W-1:0] t_coord;
    typedef struct {
        t_coord c[3];
        t_coord o[3];
        t_coord n[3];
        t_coord h[3];
    } t_pair;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_coord i_cx = '0, i_cy = '0, i_cz = '0, i_ox = '0, i_oy = '0, i_oz = '0;
    t_coord i_nx = '0, i_ny = '0, i_nz = '0, i_hx = '0, i_hy = '0, i_hz = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic o_bonded;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic signed [hbec_pkg::CUT_W-1:0] i_cfg_cutoff = '0;

    logic signed [hbec_pkg::CUT_W-1:0] cutoff_shadow;
    bit bonded_q[$];
    int err_count = 0;
    int idle_cycles = 0;
    bit rx_idling = 1'b1;
    bit hold_off = 1'b0;
    bit tx_idling = 1'b1;

    hbond_energy_check_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_carb_c_x(i_cx), .i_carb_c_y(i_cy), .i_carb_c_z(i_cz),
        .i_carb_o_x(i_ox), .i_carb_o_y(i_oy), .i_carb_o_z(i_oz),
        .i_amide_n_x(i_nx), .i_amide_n_y(i_ny), .i_amide_n_z(i_nz),
        .i_amide_h_x(i_hx), .i_amide_h_y(i_hy), .i_amide_h_z(i_hz),
        .o_valid(o_valid), .i_ready(i_ready), .o_bonded(o_bonded),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_energy_cutoff(i_cfg_cutoff)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint unsigned sq_dist(t_coord a[3], t_coord b[3]);
        longint unsigned s;
        longint d;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            d = longint'(a[i]) - longint'(b[i]);
            if (d < 0) d = -d;
            s += longint'(d) * longint'(d);
        end
        return s;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = 64'd3037000499;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic longint inv_dist(longint unsigned d2);
        longint unsigned r;
        r = floor_root(d2);
        if (r == 0) r = 1;     // coincident atoms
        return longint'((64'd1000 << FRAC) / r);
    endfunction

    function automatic bit predict_bond(t_pair p, logic signed [hbec_pkg::CUT_W-1:0] cut);
        longint unsigned dcn, mag, e;
        longint s, energy;
        bit neg;
        dcn = sq_dist(p.c, p.n);
        if (dcn > 64'd49000000) return 1'b0;
        s = inv_dist(sq_dist(p.o, p.n)) + inv_dist(sq_dist(p.c, p.h))
          - inv_dist(sq_dist(p.o, p.h)) - inv_dist(dcn);
        neg = s < 0;
        mag = longint'(neg ? -s : s) * 64'd27888;
        e = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
        if (e > 64'd10000000) e = 64'd10000000;
        energy = neg ? -longint'(e) : longint'(e);
        return energy < longint'(cut);
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR %0t: %s", $time, msg);
        err_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (bonded_q.size() == 0) report_mismatch("result beat with nothing expected");
            else begin
                bit exp_b;
                exp_b = bonded_q.pop_front();
                if (o_bonded !== exp_b)
                    report_mismatch($sformatf("bonded %b, expected %b", o_bonded, exp_b));
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (hold_off) i_ready <= 1'b0;
        else if (rx_idling && $urandom_range(0, 9) == 0) begin
            i_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
            i_ready <= 1'b1;
        end else i_ready <= 1'b1;
    end

    // watchdog on cycles with no accepted beat
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // valid stays high between back-to-back beats; it drops only for idling
    task automatic send_pair(t_pair p);
        if (tx_idling && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_cx, i_cy, i_cz} <= {p.c[0], p.c[1], p.c[2]};
        {i_ox, i_oy, i_oz} <= {p.o[0], p.o[1], p.o[2]};
        {i_nx, i_ny, i_nz} <= {p.n[0], p.n[1], p.n[2]};
        {i_hx, i_hy, i_hz} <= {p.h[0], p.h[1], p.h[2]};
        do @(posedge i_clk); while (!o_ready);
        bonded_q.push_back(predict_bond(p, cutoff_shadow));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (bonded_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_cutoff(logic signed [hbec_pkg::CUT_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_cutoff <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        cutoff_shadow = v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_coord rnd_coord();
        case ($urandom_range(0, 3))
            0: return t_coord'($urandom);
            1: return t_coord'(int'($urandom_range(0, 19999998)) - 9999999);
            default: return t_coord'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    // geometry near a real backbone contact, so the gate passes and energies vary
    function automatic t_pair near_pair();
        t_pair p;
        t_coord base;
        for (int i = 0; i < 3; i++) begin
            base = t_coord'(int'($urandom_range(0, 19999998)) - 9999999) >>> 1;
            p.c[i] = base;
            p.o[i] = base + t_coord'(int'($urandom_range(0, 2400)) - 1200);
            p.n[i] = base + t_coord'(int'($urandom_range(0, 8000)) - 4000);
            p.h[i] = p.n[i] + t_coord'(int'($urandom_range(0, 2000)) - 1000);
        end
        return p;
    endfunction

    function automatic t_pair rnd_pair();
        t_pair p;
        for (int i = 0; i < 3; i++) begin
            p.c[i] = rnd_coord(); p.o[i] = rnd_coord();
            p.n[i] = rnd_coord(); p.h[i] = rnd_coord();
        end
        return p;
    endfunction

    task automatic test_directed();
        t_pair p;
        t_coord ext[4] = '{t_coord'(-9999999), t_coord'(9999999),
                           {1'b1, {(hbec_pkg::COORD_W-1){1'b0}}},
                           {1'b0, {(hbec_pkg::COORD_W-1){1'b1}}}};
        // all atoms coincident
        p = '{default: '{default: '0}};
        send_pair(p);
        // gate exactly at 7 angstrom, and one past it
        p.n = '{t_coord'(7000), '0, '0}; p.h = '{t_coord'(7000), t_coord'(1000), '0};
        p.o = '{t_coord'(1200), '0, '0};
        send_pair(p);
        p.n[0] = t_coord'(7001); send_pair(p);
        // typical strong bond: O near H
        p.c = '{'0, '0, '0}; p.o = '{t_coord'(1230), '0, '0};
        p.n = '{t_coord'(4130), '0, '0}; p.h = '{t_coord'(3130), '0, '0};
        send_pair(p);
        // repulsive arrangement
        p.o = '{t_coord'(-1230), '0, '0}; p.n = '{t_coord'(2900), '0, '0};
        p.h = '{t_coord'(1900), '0, '0};
        send_pair(p);
        // extreme bit patterns
        foreach (ext[k]) begin
            p = '{default: '{default: ext[k]}};
            send_pair(p);
            p.n = '{default: ext[(k + 1) % 4]};
            p.h = '{default: ext[(k + 2) % 4]};
            send_pair(p);
        end
        // coincident O and H within the gate
        p = '{default: '{default: '0}};
        p.n = '{t_coord'(3000), '0, '0}; p.o = '{t_coord'(2000), '0, '0};
        p.h = p.o;
        send_pair(p);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_pair($urandom_range(0, 3) != 0 ? near_pair() : rnd_pair());
    endtask

    task automatic test_backpressure();
        int hold;
        hold = $urandom_range(150, 300);
        fork
            begin
                hold_off = 1'b1;
                repeat (hold) @(posedge i_clk);
                hold_off = 1'b0;
            end
            test_random(200);
        join
    endtask

    task automatic test_cutoff_sweep();
        logic signed [hbec_pkg::CUT_W-1:0] cuts[6] = '{-18'sd100000, 18'sd100000,
            18'sd0, -18'sd500, 18'sd1, {1'b1, {(hbec_pkg::CUT_W-1){1'b0}}}};
        foreach (cuts[k]) begin
            write_cutoff(cuts[k]);
            test_random(60);
        end
        write_cutoff({1'b0, {(hbec_pkg::CUT_W-1){1'b1}}});
        test_random(60);
        write_cutoff(18'(int'($urandom_range(0, 200000)) - 100000));
        test_random(300);
    endtask

    initial begin
        cutoff_shadow = hbec_pkg::CUTOFF_RST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(500);
        test_backpressure();
        test_cutoff_sweep();
        rx_idling = 1'b0;
        tx_idling = 1'b0;
        test_random(150);
        drain();
        if (err_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
